/* rtl/core/short_name_packer_defines.svh */
// assertion macros shared by the short name packer rtl
// expects clk and rst in scope at the point of use
`ifndef SHORT_NAME_PACKER_DEFINES_SVH
`define SHORT_NAME_PACKER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SNP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("short_name_packer: check failed");
`define SNP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("short_name_packer: check failed");
`else
`define SNP_ASSERT(label, prop)
`define SNP_ASSERT_IMPL(label, ante, cons)
`endif

`endif

/* rtl/core/snp_pkg.sv */
// types and constants for the short name packer
// no dependencies
package snp_pkg;

  localparam int BASE_CHARS = 8;
  localparam int EXT_CHARS  = 3;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] NUL_CHAR   = 8'h00;

  // counters hold 0..limit, indexes hold 0..limit-1
  localparam int BCW = $clog2(BASE_CHARS + 1);
  localparam int ECW = $clog2(EXT_CHARS + 1);
  localparam int BIW = (BASE_CHARS > 1) ? $clog2(BASE_CHARS) : 1;
  localparam int EIW = (EXT_CHARS > 1) ? $clog2(EXT_CHARS) : 1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_W       = 1 + 8 * BASE_CHARS + 8 * EXT_CHARS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic [BASE_CHARS-1:0][7:0] base_bytes_t;
  typedef logic [EXT_CHARS-1:0][7:0]  ext_bytes_t;

  typedef struct packed {
    base_bytes_t    base_bytes;
    ext_bytes_t     ext_bytes;
    logic [BCW-1:0] base_count;
    logic [ECW-1:0] ext_count;
    logic           after_dot;
    logic           failed;
  } state_t;

  typedef struct packed {
    ext_bytes_t  ext_name;
    base_bytes_t base_name;
    logic        status;
  } result_t;

  localparam state_t STATE_INIT = '{
    base_bytes: {BASE_CHARS{SPACE_CHAR}},
    ext_bytes:  {EXT_CHARS{SPACE_CHAR}},
    base_count: '0,
    ext_count:  '0,
    after_dot:  1'b0,
    failed:     1'b0
  };

endpackage

/* rtl/core/snp_step.sv */
// per-character update of the short name state and the result on a terminator
// depends on snp_pkg
module snp_step (
  input  snp_pkg::state_t  cur,
  input  logic [7:0]       character,
  output snp_pkg::state_t  nxt,
  output snp_pkg::result_t res,
  output logic             is_term
);
  import snp_pkg::*;

  localparam logic [BCW-1:0] BASE_FULL = BCW'(BASE_CHARS);
  localparam logic [ECW-1:0] EXT_FULL  = ECW'(EXT_CHARS);
  localparam logic [BIW-1:0] BASE_TOP  = BIW'(BASE_CHARS - 1);
  localparam logic [EIW-1:0] EXT_TOP   = EIW'(EXT_CHARS - 1);

  logic           bad;
  logic [BIW-1:0] base_idx;
  logic [EIW-1:0] ext_idx;

  assign is_term  = (character == NUL_CHAR);
  // first character lands in the most significant byte
  assign base_idx = BASE_TOP - cur.base_count[BIW-1:0];
  assign ext_idx  = EXT_TOP - cur.ext_count[EIW-1:0];

  always_comb begin
    bad = cur.failed
          || (!cur.after_dot && (cur.base_count == '0))
          || (cur.after_dot && (cur.ext_count == '0));
    res.status    = bad;
    res.base_name = bad ? {BASE_CHARS{SPACE_CHAR}} : cur.base_bytes;
    res.ext_name  = bad ? {EXT_CHARS{SPACE_CHAR}} : cur.ext_bytes;
  end

  always_comb begin
    nxt = cur;
    if (is_term) begin
      nxt = STATE_INIT;
    end else if (!cur.failed) begin
      if (!cur.after_dot) begin
        if (character == DOT_CHAR) begin
          if (cur.base_count == '0) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.after_dot = 1'b1;
          end
        end else if (cur.base_count >= BASE_FULL) begin
          nxt.failed = 1'b1;
        end else begin
          nxt.base_bytes[base_idx] = character;
          nxt.base_count = cur.base_count + 1'b1;
        end
      end else begin
        if (character == DOT_CHAR) begin
          nxt.failed = 1'b1;
        end else if (cur.ext_count >= EXT_FULL) begin
          nxt.failed = 1'b1;
        end else begin
          nxt.ext_bytes[ext_idx] = character;
          nxt.ext_count = cur.ext_count + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/short_name_packer.sv */
// Short name packer: takes a file name one byte per transaction and, on the
// zero terminator, emits one 8.3 short name (status, space padded base and
// extension). Bytes are copied unchanged. Throughput is one character per
// clock while no terminator waits for the result register: each byte passes
// an input register, a single update of the name state, and on a terminator
// the result register. A result waiting on m_tready only holds back a
// following terminator; ordinary characters keep flowing.
// depends on snp_pkg, snp_step and short_name_packer_defines.svh
`include "short_name_packer_defines.svh"

module short_name_packer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [snp_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] character
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [snp_pkg::OUT_TDATA_W-1:0] m_tdata   // [0] status, [64:1] base_name,
                                                    // [88:65] extension_name, rest zero
);
  import snp_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  state_t     state;
  state_t     state_next;
  result_t    res;
  logic       is_term;
  logic       out_free;
  logic       consume;

  snp_step u_step (
    .cur       (state),
    .character (in_char),
    .nxt       (state_next),
    .res       (res),
    .is_term   (is_term)
  );

  assign out_free = !m_tvalid || m_tready;
  // only a terminator needs room in the result register
  assign consume  = in_valid && (!is_term || out_free);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      state    <= STATE_INIT;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (consume) begin
        state <= state_next;
      end
      if (consume && is_term) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata[7:0];
    end
    if (consume && is_term) begin
      m_tdata <= OUT_TDATA_W'(res);
    end
  end

  `SNP_ASSERT_IMPL(a_result_from_term, $rose(m_tvalid), $past(consume && is_term))
  `SNP_ASSERT_IMPL(a_bad_name_spaces, m_tvalid && m_tdata[0],
                   m_tdata[OUT_W-1:1] == {(BASE_CHARS + EXT_CHARS){SPACE_CHAR}})
  `SNP_ASSERT_IMPL(a_state_cleared, $past(consume && is_term),
                   (state.base_count == '0) && (state.ext_count == '0)
                   && !state.after_dot && !state.failed)
  `SNP_ASSERT(a_base_count_range, state.base_count <= BCW'(BASE_CHARS))

endmodule
